// ----- hdl/motion_intensity_from_imu_core_assert.svh -----
// Assertion macros for the motion intensity core.
`ifndef MOTION_INTENSITY_FROM_IMU_CORE_ASSERT_SVH
`define MOTION_INTENSITY_FROM_IMU_CORE_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define MII_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("motion intensity core: same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define MII_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("motion intensity core: next-cycle check failed");

`endif

// ----- hdl/mii_pkg.sv -----
package mii_pkg;

    // Field and register widths
    localparam int SAMPLE_W    = 16;
    localparam int SQ_W        = 32;
    localparam int ROOT_W      = 16;
    localparam int GRAVITY_W   = 15;
    localparam int WEIGHT_W    = 16;
    localparam int INTENSITY_W = 19;
    localparam int PROD_W      = ROOT_W + WEIGHT_W;
    localparam int WEIGHT_SHIFT = 10;
    localparam int ROT_W       = PROD_W - WEIGHT_SHIFT;
    localparam int SUM_W       = ROT_W + 1;

    // Stream widths
    localparam int IN_DATA_W   = 6 * SAMPLE_W;
    localparam int OUT_DATA_W  = 24;

    // Configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRAVITY = 1'b0,
        REG_WEIGHT  = 1'b1
    } cfg_reg_t;

    localparam logic [GRAVITY_W-1:0]   GRAVITY_RESET = 15'd4096;
    localparam logic [WEIGHT_W-1:0]    WEIGHT_RESET  = 16'd6554;
    localparam logic [INTENSITY_W-1:0] INTENSITY_MAX = {INTENSITY_W{1'b1}};

    // Pipeline layout: squares, root steps, combine
    localparam int SQUARE_STAGES  = 2;
    localparam int ROOT_STAGES    = 8;
    localparam int COMBINE_STAGES = 2;
    localparam int PIPE_STAGES    = SQUARE_STAGES + ROOT_STAGES + COMBINE_STAGES;
    localparam int ROOT_FIRST     = SQUARE_STAGES;
    localparam int COMBINE_FIRST  = SQUARE_STAGES + ROOT_STAGES;

    // Partial state of the digit-by-digit square root
    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } root_state_t;

    // Magnitude of a two's complement sample; the most negative value maps to 2^15
    function automatic logic [SAMPLE_W-1:0] abs_sample(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] neg;
        neg = ~v + 1'b1;
        return v[SAMPLE_W-1] ? neg : v;
    endfunction

    // One restoring square root step for the given bit weight
    function automatic root_state_t root_step(input root_state_t st,
                                              input logic [SQ_W-1:0] bit_w);
        root_state_t     res;
        logic [SQ_W-1:0] trial;
        trial = st.root + bit_w;
        if (st.rem >= trial) begin
            res.rem  = st.rem - trial;
            res.root = (st.root >> 1) + bit_w;
        end else begin
            res.rem  = st.rem;
            res.root = st.root >> 1;
        end
        return res;
    endfunction

endpackage

// ----- hdl/mii_square.sv -----
module mii_square (
    input  logic                                   clk,
    input  logic [mii_pkg::SQUARE_STAGES-1:0]      en,
    input  logic [mii_pkg::SAMPLE_W-1:0]           accel_x,
    input  logic [mii_pkg::SAMPLE_W-1:0]           accel_y,
    input  logic [mii_pkg::SAMPLE_W-1:0]           accel_z,
    input  logic [mii_pkg::SAMPLE_W-1:0]           rate_x,
    input  logic [mii_pkg::SAMPLE_W-1:0]           rate_y,
    input  logic [mii_pkg::SAMPLE_W-1:0]           rate_z,
    output logic [mii_pkg::SQ_W-1:0]               accel_sum,
    output logic [mii_pkg::SQ_W-1:0]               rate_sum
);

    logic [mii_pkg::SAMPLE_W-1:0] mag [6];
    logic [mii_pkg::SQ_W-1:0]     sq_next [6];
    logic [mii_pkg::SQ_W-1:0]     sq_reg [6];
    logic [mii_pkg::SQ_W-1:0]     accel_sum_next;
    logic [mii_pkg::SQ_W-1:0]     rate_sum_next;
    logic [mii_pkg::SQ_W-1:0]     accel_sum_reg;
    logic [mii_pkg::SQ_W-1:0]     rate_sum_reg;

    // Take magnitudes and square each axis
    always_comb
    begin
        mag[0] = mii_pkg::abs_sample(accel_x);
        mag[1] = mii_pkg::abs_sample(accel_y);
        mag[2] = mii_pkg::abs_sample(accel_z);
        mag[3] = mii_pkg::abs_sample(rate_x);
        mag[4] = mii_pkg::abs_sample(rate_y);
        mag[5] = mii_pkg::abs_sample(rate_z);
        for (int i = 0; i < 6; i++)
        begin
            sq_next[i] = mii_pkg::SQ_W'(mag[i]) * mii_pkg::SQ_W'(mag[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sq_reg <= sq_next;
        end
    end

    // Sum the squares of each vector; at most 3 * 2^30, so no carry out
    assign accel_sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    assign rate_sum_next  = sq_reg[3] + sq_reg[4] + sq_reg[5];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            accel_sum_reg <= accel_sum_next;
            rate_sum_reg  <= rate_sum_next;
        end
    end

    assign accel_sum = accel_sum_reg;
    assign rate_sum  = rate_sum_reg;

endmodule

// ----- hdl/mii_isqrt.sv -----
module mii_isqrt (
    input  logic                                clk,
    input  logic [mii_pkg::ROOT_STAGES-1:0]     en,
    input  logic [mii_pkg::SQ_W-1:0]            radicand,
    output logic [mii_pkg::ROOT_W-1:0]          root
);

    mii_pkg::root_state_t st_in   [mii_pkg::ROOT_STAGES];
    mii_pkg::root_state_t st_next [mii_pkg::ROOT_STAGES];
    mii_pkg::root_state_t st_reg  [mii_pkg::ROOT_STAGES];

    assign st_in[0] = '{rem: radicand, root: '0};

    // Two root bits per stage, most significant first
    for (genvar s = 0; s < mii_pkg::ROOT_STAGES; s++)
    begin : g_stage
        localparam logic [mii_pkg::SQ_W-1:0] BIT_HI =
            mii_pkg::SQ_W'(1) << (mii_pkg::SQ_W - 2 - 4 * s);
        localparam logic [mii_pkg::SQ_W-1:0] BIT_LO =
            mii_pkg::SQ_W'(1) << (mii_pkg::SQ_W - 4 - 4 * s);

        if (s > 0)
        begin : g_link
            assign st_in[s] = st_reg[s-1];
        end

        assign st_next[s] = mii_pkg::root_step(mii_pkg::root_step(st_in[s], BIT_HI), BIT_LO);

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign root = st_reg[mii_pkg::ROOT_STAGES-1].root[mii_pkg::ROOT_W-1:0];

endmodule

// ----- hdl/mii_combine.sv -----
module mii_combine (
    input  logic                                  clk,
    input  logic [mii_pkg::COMBINE_STAGES-1:0]    en,
    input  logic [mii_pkg::ROOT_W-1:0]            accel_mag,
    input  logic [mii_pkg::ROOT_W-1:0]            rate_mag,
    input  logic [mii_pkg::GRAVITY_W-1:0]         gravity_reference,
    input  logic [mii_pkg::WEIGHT_W-1:0]          rotation_weight,
    output logic [mii_pkg::INTENSITY_W-1:0]       intensity
);

    logic [mii_pkg::ROOT_W-1:0]      gravity_ext;
    logic [mii_pkg::ROOT_W-1:0]      dev_next;
    logic [mii_pkg::PROD_W-1:0]      prod_next;
    logic [mii_pkg::ROOT_W-1:0]      dev_reg;
    logic [mii_pkg::PROD_W-1:0]      prod_reg;
    logic [mii_pkg::SUM_W-1:0]       sum;
    logic [mii_pkg::INTENSITY_W-1:0] intensity_next;
    logic [mii_pkg::INTENSITY_W-1:0] intensity_reg;

    // Deviation from gravity and weighted rotation product
    assign gravity_ext = mii_pkg::ROOT_W'(gravity_reference);
    assign dev_next    = (accel_mag >= gravity_ext) ? accel_mag - gravity_ext
                                                    : gravity_ext - accel_mag;
    assign prod_next   = mii_pkg::PROD_W'(rate_mag) * mii_pkg::PROD_W'(rotation_weight);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dev_reg  <= dev_next;
            prod_reg <= prod_next;
        end
    end

    // Drop the fraction bits of the product, add and saturate
    assign sum = mii_pkg::SUM_W'(dev_reg)
               + mii_pkg::SUM_W'(prod_reg[mii_pkg::PROD_W-1:mii_pkg::WEIGHT_SHIFT]);
    assign intensity_next = (sum > mii_pkg::SUM_W'(mii_pkg::INTENSITY_MAX))
                          ? mii_pkg::INTENSITY_MAX
                          : sum[mii_pkg::INTENSITY_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            intensity_reg <= intensity_next;
        end
    end

    assign intensity = intensity_reg;

endmodule

// ----- hdl/motion_intensity_from_imu_core.sv -----
// Motion intensity from one IMU sample per item.
// Input stream s_axis: tdata carries the accelerometer vector (Q4.12 g) and
// the gyroscope vector (Q10.6 deg/s). Output stream m_axis: tdata carries the
// intensity in unsigned Q7.12, saturated at its maximum; one result per item.
// Configuration: cfg_we writes cfg_data to the register named by cfg_index
// (0: gravity reference, 1: rotation weight); write only while no item is in
// flight.
// The pipeline has 12 register stages. Two stages form the squared norms,
// eight stages run the square roots two bits at a time, and two stages form
// the deviation, the weighted rotation term and the saturated sum. The
// pipeline takes one item per cycle while m_axis_tready is high.
// Each stage holds a valid bit; when m_axis_tready is low, items close up into
// empty stages, and s_axis_tready drops only once every stage is full.
// Reset clears all valid bits and loads the register defaults (1.0 g and a
// weight of 6554/1024).
`include "motion_intensity_from_imu_core_assert.svh"

module motion_intensity_from_imu_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    input  logic [mii_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // intensity, then zero padding
    output logic [mii_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                cfg_we,
    input  logic [mii_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mii_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int SW = mii_pkg::SAMPLE_W;
    localparam int PS = mii_pkg::PIPE_STAGES;

    logic [mii_pkg::GRAVITY_W-1:0]   gravity_reg;
    logic [mii_pkg::WEIGHT_W-1:0]    weight_reg;
    logic [PS-1:0]                   vld_reg;
    logic [PS-1:0]                   vld_next;
    logic [PS-1:0]                   vld_feed;
    logic [PS-1:0]                   stage_rdy;
    logic [mii_pkg::SQ_W-1:0]        accel_sum;
    logic [mii_pkg::SQ_W-1:0]        rate_sum;
    logic [mii_pkg::ROOT_W-1:0]      accel_mag;
    logic [mii_pkg::ROOT_W-1:0]      rate_mag;
    logic [mii_pkg::INTENSITY_W-1:0] intensity;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= mii_pkg::GRAVITY_RESET;
            weight_reg  <= mii_pkg::WEIGHT_RESET;
        end else if (cfg_we)
        begin
            case (mii_pkg::cfg_reg_t'(cfg_index))
                mii_pkg::REG_GRAVITY: gravity_reg <= cfg_data[mii_pkg::GRAVITY_W-1:0];
                mii_pkg::REG_WEIGHT:  weight_reg  <= cfg_data[mii_pkg::WEIGHT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Stage ready: a stage loads when empty or when its successor moves on
    always_comb
    begin
        stage_rdy[PS-1] = !vld_reg[PS-1] || m_axis_tready;
        for (int i = PS - 2; i >= 0; i--)
        begin
            stage_rdy[i] = !vld_reg[i] || stage_rdy[i+1];
        end
    end

    // Advance valid bits alongside the data
    assign vld_feed = {vld_reg[PS-2:0], s_axis_tvalid};
    assign vld_next = (stage_rdy & vld_feed) | (~stage_rdy & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end else
        begin
            vld_reg <= vld_next;
        end
    end

    mii_square u_square (
        .clk       (clk),
        .en        (stage_rdy[mii_pkg::SQUARE_STAGES-1:0]),
        .accel_x   (s_axis_tdata[0*SW +: SW]),
        .accel_y   (s_axis_tdata[1*SW +: SW]),
        .accel_z   (s_axis_tdata[2*SW +: SW]),
        .rate_x    (s_axis_tdata[3*SW +: SW]),
        .rate_y    (s_axis_tdata[4*SW +: SW]),
        .rate_z    (s_axis_tdata[5*SW +: SW]),
        .accel_sum (accel_sum),
        .rate_sum  (rate_sum)
    );

    mii_isqrt u_accel_root (
        .clk      (clk),
        .en       (stage_rdy[mii_pkg::ROOT_FIRST +: mii_pkg::ROOT_STAGES]),
        .radicand (accel_sum),
        .root     (accel_mag)
    );

    mii_isqrt u_rate_root (
        .clk      (clk),
        .en       (stage_rdy[mii_pkg::ROOT_FIRST +: mii_pkg::ROOT_STAGES]),
        .radicand (rate_sum),
        .root     (rate_mag)
    );

    mii_combine u_combine (
        .clk               (clk),
        .en                (stage_rdy[mii_pkg::COMBINE_FIRST +: mii_pkg::COMBINE_STAGES]),
        .accel_mag         (accel_mag),
        .rate_mag          (rate_mag),
        .gravity_reference (gravity_reg),
        .rotation_weight   (weight_reg),
        .intensity         (intensity)
    );

    assign s_axis_tready = stage_rdy[0];
    assign m_axis_tvalid = vld_reg[PS-1];
    assign m_axis_tdata  = {{(mii_pkg::OUT_DATA_W - mii_pkg::INTENSITY_W){1'b0}}, intensity};

    // An empty first stage always takes an item
    `MII_ASSERT_NOW(a_first_stage_ready, !vld_reg[0], s_axis_tready)
    // A ready receiver lets the whole pipeline move
    `MII_ASSERT_NOW(a_ready_passes_through, m_axis_tready, s_axis_tready)
    // An item taken in with none leaving adds exactly one valid bit
    `MII_ASSERT_NEXT(a_item_count,
        s_axis_tvalid && s_axis_tready && !(m_axis_tvalid && m_axis_tready),
        $countones(vld_reg) == $past($countones(vld_reg)) + 1)

endmodule
